// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core of the sorted run set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/srsp_pkg.sv =====
// Types and constants for the sorted run set point insert block.
package srsp_pkg;

  localparam int MAX_LINE = 1024;

  localparam int StartW = 10;
  localparam int LengthW = 11;
  localparam int PosW = 12;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [StartW-1:0]  start;
    logic [LengthW-1:0] length;
  } run_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_MERGE_READ,
    ST_MERGE_CHECK,
    ST_UP_READ,
    ST_UP_WRITE,
    ST_PLACE,
    ST_DOWN_READ,
    ST_DOWN_WRITE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/sorted_run_set_point_insert_core.sv =====
// Sorted run set for one display line. The runs (start, length) sit sorted
// in one single-port-read, single-port-write memory with a registered read,
// and each query or insert walks that memory one entry at a time, so the
// block works on one transaction at a time. A clear and a refused or unused
// command go from acceptance straight to the finish state. A query or
// insert reads and checks runs in turn (at most the run count), with one
// more read state when the pixel lies past the last run. An insert that
// opens a new run adds a place state, after an up read and write per run
// moved up to make room. An insert that extends a run to the right while
// another run follows adds a merge read and check of that run, plus a down
// read and write per run moved down when the two join. Every entry access
// is a separate read or write cycle, so no read ever meets a write to the
// same entry. A new transaction is taken while the last result still waits
// in the output register, and the next waits in ST_FINISH until it is taken.
`include "assert_macros.svh"

module sorted_run_set_point_insert_core
  import srsp_pkg::*;
#(
  parameter int MAX_RUNS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [9:0]  pixel_x,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        covered,
  output logic [6:0]  run_total,
  output logic [1:0]  status
);

  localparam int IdxW = $clog2(MAX_RUNS);
  localparam int CntW = $clog2(MAX_RUNS + 1);

  state_t state, state_next;

  logic [10:0]      line_width;
  logic [CntW-1:0]  run_used, run_used_next;
  logic [CntW-1:0]  idx, idx_next;
  logic [CntW-1:0]  ptr, ptr_next;
  logic [9:0]       x_q, x_q_next;
  logic             ins_q, ins_q_next;
  run_t             cur, cur_next;
  logic             res_covered, res_covered_next;
  logic [1:0]       res_status, res_status_next;
  logic             out_valid_next;
  logic             covered_next;
  logic [6:0]       run_total_next;
  logic [1:0]       status_next;

  run_t             run_mem [MAX_RUNS];
  run_t             rd_data;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  run_t             mem_wdata;

  logic             x_in_range;
  logic [PosW-1:0]  x_ext, x_p1, s_ext, e_ext, cur_e;
  logic [CntW-1:0]  idx_p1, ptr_p1, ptr_m1;
  logic [CntW:0]    idx_p2;
  logic             list_full;
  logic [31:0]      used_ext;

  assign in_ready = (state == ST_IDLE);

  assign x_in_range = (32'(pixel_x) < 32'(line_width)) && (32'(pixel_x) < MAX_LINE);
  assign x_ext = PosW'(x_q);
  assign x_p1 = x_ext + PosW'(1);
  assign s_ext = PosW'(rd_data.start);
  assign e_ext = s_ext + PosW'(rd_data.length);
  assign cur_e = PosW'(cur.start) + PosW'(cur.length);
  assign idx_p1 = idx + CntW'(1);
  assign idx_p2 = {1'b0, idx} + (CntW + 1)'(2);
  assign ptr_p1 = ptr + CntW'(1);
  assign ptr_m1 = ptr - CntW'(1);
  assign list_full = (run_used == CntW'(MAX_RUNS));

  always_comb begin
    state_next = state;
    run_used_next = run_used;
    idx_next = idx;
    ptr_next = ptr;
    x_q_next = x_q;
    ins_q_next = ins_q;
    cur_next = cur;
    res_covered_next = res_covered;
    res_status_next = res_status;
    out_valid_next = out_valid && !out_ready;
    covered_next = covered;
    run_total_next = run_total;
    status_next = status;
    mem_re = 1'b0;
    mem_raddr = idx[IdxW-1:0];
    mem_we = 1'b0;
    mem_waddr = idx[IdxW-1:0];
    mem_wdata = '0;
    used_ext = 32'(run_used);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          idx_next = '0;
          x_q_next = pixel_x;
          ins_q_next = (command == CMD_INSERT);
          res_covered_next = 1'b0;
          res_status_next = STATUS_OK;
          state_next = ST_FINISH;
          unique case (command)
            CMD_CLEAR: begin
              run_used_next = '0;
            end
            CMD_INSERT, CMD_QUERY: begin
              if (x_in_range) begin
                state_next = ST_READ;
              end else begin
                res_status_next = STATUS_RANGE;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_READ: begin
        if (idx == run_used) begin
          // End of the list: the pixel goes after every run.
          state_next = ST_FINISH;
          if (ins_q) begin
            if (list_full) begin
              res_status_next = STATUS_FULL;
            end else begin
              state_next = ST_PLACE;
            end
          end
        end else begin
          mem_re = 1'b1;
          mem_raddr = idx[IdxW-1:0];
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        cur_next = rd_data;
        state_next = ST_FINISH;
        priority if (x_p1 < s_ext) begin
          if (ins_q) begin
            if (list_full) begin
              res_status_next = STATUS_FULL;
            end else begin
              ptr_next = run_used - CntW'(1);
              state_next = ST_UP_READ;
            end
          end
        end else if (x_p1 == s_ext) begin
          if (ins_q) begin
            mem_we = 1'b1;
            mem_waddr = idx[IdxW-1:0];
            mem_wdata.start = rd_data.start - StartW'(1);
            mem_wdata.length = rd_data.length + LengthW'(1);
          end
        end else if (x_ext >= s_ext && x_ext < e_ext) begin
          res_covered_next = 1'b1;
        end else if (x_ext == e_ext) begin
          if (ins_q) begin
            if (idx_p1 < run_used) begin
              state_next = ST_MERGE_READ;
            end else begin
              mem_we = 1'b1;
              mem_waddr = idx[IdxW-1:0];
              mem_wdata.start = rd_data.start;
              mem_wdata.length = rd_data.length + LengthW'(1);
            end
          end
        end else begin
          idx_next = idx_p1;
          state_next = ST_READ;
        end
      end

      ST_MERGE_READ: begin
        mem_re = 1'b1;
        mem_raddr = idx_p1[IdxW-1:0];
        state_next = ST_MERGE_CHECK;
      end

      ST_MERGE_CHECK: begin
        mem_we = 1'b1;
        mem_waddr = idx[IdxW-1:0];
        mem_wdata.start = cur.start;
        state_next = ST_FINISH;
        if (PosW'(rd_data.start) == cur_e + PosW'(1)) begin
          // The extended run now touches the next one: fold it in.
          mem_wdata.length = cur.length + LengthW'(1) + rd_data.length;
          if (idx_p2 < {1'b0, run_used}) begin
            ptr_next = idx_p2[CntW-1:0];
            state_next = ST_DOWN_READ;
          end else begin
            run_used_next = run_used - CntW'(1);
          end
        end else begin
          mem_wdata.length = cur.length + LengthW'(1);
        end
      end

      ST_DOWN_READ: begin
        mem_re = 1'b1;
        mem_raddr = ptr[IdxW-1:0];
        state_next = ST_DOWN_WRITE;
      end

      ST_DOWN_WRITE: begin
        mem_we = 1'b1;
        mem_waddr = ptr_m1[IdxW-1:0];
        mem_wdata = rd_data;
        if (ptr_p1 == run_used) begin
          run_used_next = run_used - CntW'(1);
          state_next = ST_FINISH;
        end else begin
          ptr_next = ptr_p1;
          state_next = ST_DOWN_READ;
        end
      end

      ST_UP_READ: begin
        mem_re = 1'b1;
        mem_raddr = ptr[IdxW-1:0];
        state_next = ST_UP_WRITE;
      end

      ST_UP_WRITE: begin
        mem_we = 1'b1;
        mem_waddr = ptr_p1[IdxW-1:0];
        mem_wdata = rd_data;
        if (ptr == idx) begin
          state_next = ST_PLACE;
        end else begin
          ptr_next = ptr_m1;
          state_next = ST_UP_READ;
        end
      end

      ST_PLACE: begin
        mem_we = 1'b1;
        mem_waddr = idx[IdxW-1:0];
        mem_wdata.start = x_q;
        mem_wdata.length = LengthW'(1);
        run_used_next = run_used + CntW'(1);
        state_next = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          covered_next = res_covered;
          run_total_next = used_ext[6:0];
          status_next = res_status;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      run_used <= '0;
      out_valid <= 1'b0;
      line_width <= 11'd320;
    end else begin
      state <= state_next;
      run_used <= run_used_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        line_width <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    ptr <= ptr_next;
    x_q <= x_q_next;
    ins_q <= ins_q_next;
    cur <= cur_next;
    res_covered <= res_covered_next;
    res_status <= res_status_next;
    covered <= covered_next;
    run_total <= run_total_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      run_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= run_mem[mem_raddr];
    end
  end

  `ASSERT_ALWAYS(a_reset_empty, rst |=> (run_used == '0 && !out_valid), "reset left state behind")
  `ASSERT_CLK(a_used_bound, run_used <= CntW'(MAX_RUNS), "run count exceeds capacity")
  `ASSERT_CLK(a_write_in_list, mem_we |-> (CntW'(mem_waddr) <= run_used), "write past list end")
  `ASSERT_CLK(a_clear_fast, (in_ready && in_valid && command == CMD_CLEAR) |=> (state == ST_FINISH && run_used == '0), "clear did not empty list")

endmodule

// ===== tb/sorted_run_set_point_insert_core_tb.sv =====
// Self-checking testbench for the sorted run set point insert core, with its own run list predictor.
module sorted_run_set_point_insert_core_tb
  import srsp_pkg::*;
;

  localparam int RUN_SLOTS = 64;
  localparam int STALL_LIMIT = 3000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic       covered;
    logic [6:0] run_total;
    logic [1:0] status;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [9:0]  pixel_x;
  logic        out_valid;
  logic        out_ready;
  logic        covered;
  logic [6:0]  run_total;
  logic [1:0]  status;

  // Predicted line state.
  logic [StartW-1:0]  run_begin [RUN_SLOTS];
  logic [LengthW-1:0] run_span [RUN_SLOTS];
  int                 run_count = 0;
  logic [10:0]        width_model = 11'd320;

  line_result_t pending_results[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;

  sorted_run_set_point_insert_core #(
    .MAX_RUNS(RUN_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .pixel_x(pixel_x),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .covered(covered),
    .run_total(run_total),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit pixel_in_run(int x);
    for (int i = 0; i < run_count; i++) begin
      if (x >= int'(run_begin[i]) && x < int'(run_begin[i]) + int'(run_span[i])) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] open_run(int pos, int x);
    if (run_count >= RUN_SLOTS) return STATUS_FULL;
    for (int j = run_count; j > pos; j--) begin
      run_begin[j] = run_begin[j-1];
      run_span[j] = run_span[j-1];
    end
    run_begin[pos] = StartW'(x);
    run_span[pos] = LengthW'(1);
    run_count++;
    return STATUS_OK;
  endfunction

  function automatic logic [1:0] add_pixel(int x);
    int lo;
    int hi;
    for (int i = 0; i < run_count; i++) begin
      lo = run_begin[i];
      hi = lo + int'(run_span[i]);
      if (x + 1 < lo) return open_run(i, x);
      if (x + 1 == lo) begin
        run_begin[i] = StartW'(lo - 1);
        run_span[i] = run_span[i] + 1'b1;
        return STATUS_OK;
      end
      if (x >= lo && x < hi) return STATUS_OK;
      if (x == hi) begin
        run_span[i] = run_span[i] + 1'b1;
        // The grown run now touches the next one, so the two become one.
        if (i + 1 < run_count && hi + 1 == int'(run_begin[i+1])) begin
          run_span[i] = run_span[i] + run_span[i+1];
          for (int j = i + 1; j < run_count - 1; j++) begin
            run_begin[j] = run_begin[j+1];
            run_span[j] = run_span[j+1];
          end
          run_count--;
        end
        return STATUS_OK;
      end
    end
    return open_run(run_count, x);
  endfunction

  function automatic line_result_t run_set_step(logic [1:0] cmd, logic [9:0] x);
    line_result_t r;
    int lim;
    lim = (width_model < MAX_LINE) ? int'(width_model) : MAX_LINE;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      run_count = 0;
    end else if (cmd == CMD_INSERT || cmd == CMD_QUERY) begin
      if (int'(x) >= lim) begin
        r.status = STATUS_RANGE;
      end else begin
        r.covered = pixel_in_run(x);
        if (cmd == CMD_INSERT && !r.covered) r.status = add_pixel(x);
      end
    end
    r.run_total = run_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Predicts on every accepted command and checks every accepted result.
  always @(posedge clk) begin : result_monitor
    line_result_t want;
    if (!rst) begin
      if (cfg_we) width_model = cfg_wdata;
      if (in_valid && in_ready) begin
        pending_results = {pending_results, run_set_step(command, pixel_x)};
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (covered !== want.covered) report_mismatch("covered", covered, want.covered);
          if (run_total !== want.run_total) begin
            report_mismatch("run_total", run_total, want.run_total);
          end
          if (status !== want.status) report_mismatch("status", status, want.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idling(int sender_gap, int receiver_stall);
    gap_pct = sender_gap;
    stall_pct = receiver_stall;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(logic [1:0] cmd, logic [9:0] x);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    pixel_x <= x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_line_width(logic [10:0] value);
    drain_results();
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    set_line_width(11'd320);
    send_item(CMD_QUERY, 10'd0);
    send_item(CMD_INSERT, 10'd5);
    send_item(CMD_INSERT, 10'd5);
    send_item(CMD_INSERT, 10'd7);
    send_item(CMD_INSERT, 10'd6);
    send_item(CMD_INSERT, 10'd4);
    send_item(CMD_INSERT, 10'd2);
    send_item(CMD_INSERT, 10'd9);
    send_item(CMD_INSERT, 10'd8);
    send_item(CMD_QUERY, 10'd6);
    send_item(CMD_QUERY, 10'd3);
    send_item(CMD_INSERT, 10'd319);
    send_item(CMD_QUERY, 10'd319);
    send_item(CMD_QUERY, 10'd320);
    send_item(CMD_INSERT, 10'd1023);
    send_item(CMD_UNUSED, 10'd1023);
    send_item(CMD_UNUSED, 10'd0);
    send_item(CMD_CLEAR, 10'd1023);
    send_item(CMD_QUERY, 10'd5);
    send_item(CMD_INSERT, 10'd0);
    send_item(CMD_QUERY, 10'd0);
  endtask

  task automatic test_width_extremes();
    set_idling(21, 21);
    set_line_width(11'd1024);
    send_item(CMD_INSERT, 10'd1023);
    send_item(CMD_INSERT, 10'd1022);
    send_item(CMD_QUERY, 10'd1023);
    // Widths past the line maximum are clamped to it.
    set_line_width(11'd2047);
    send_item(CMD_INSERT, 10'd1021);
    send_item(CMD_QUERY, 10'd1021);
    set_line_width(11'd0);
    send_item(CMD_QUERY, 10'd0);
    send_item(CMD_INSERT, 10'd0);
    set_line_width(11'd1);
    send_item(CMD_INSERT, 10'd0);
    send_item(CMD_QUERY, 10'd1);
    send_item(CMD_INSERT, 10'd1);
  endtask

  task automatic test_full_list();
    int base;
    set_idling(0, 51);
    set_line_width(11'd1024);
    base = $urandom_range(800, 2);
    send_item(CMD_CLEAR, 10'd0);
    // Isolated pixels, one run each, until every slot is taken.
    for (int k = 0; k < RUN_SLOTS; k++) send_item(CMD_INSERT, 10'(base + 2 * k));
    send_item(CMD_INSERT, 10'(base + 2 * RUN_SLOTS));
    send_item(CMD_INSERT, 10'(base - 2));
    send_item(CMD_INSERT, 10'(base + 1));
    send_item(CMD_INSERT, 10'(base + 200));
    send_item(CMD_INSERT, 10'(base + 5 + 2 * ($urandom_range(20))));
    send_item(CMD_INSERT, 10'(base + 201));
    send_item(CMD_INSERT, 10'(base - 1));
    send_item(CMD_QUERY, 10'(base + 2 * RUN_SLOTS - 2));
    send_item(CMD_QUERY, 10'(base + 2 * RUN_SLOTS));
  endtask

  task automatic test_random_runs();
    int lim;
    int hi;
    int lo;
    int span;
    int x;
    int pick;
    int sent;
    int target;
    bit sparse;
    lo = 0;
    span = 24;
    sparse = 1'b0;
    for (int phase = 0; phase < 16; phase++) begin
      unique case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(51, 0);
        2: set_idling(0, 51);
        default: set_idling(21, 21);
      endcase
      unique case (phase)
        0: set_line_width(11'd320);
        1: set_line_width(11'd1024);
        2: set_line_width(11'd2047);
        3: set_line_width(11'd1);
        4: set_line_width(11'd0);
        5: set_line_width(11'd1023);
        default: set_line_width(11'($urandom_range(1024, 2)));
      endcase
      lim = (width_model < MAX_LINE) ? int'(width_model) : MAX_LINE;
      target = (lim == 0) ? 30 : 140;
      sent = 0;
      while (sent < target) begin
        // A fresh window now and then; most traffic lands inside it so runs grow and merge.
        if (sent % 48 == 0) begin
          span = $urandom_range(220, 24);
          hi = (lim > 0) ? lim - 1 : 0;
          lo = (hi > span) ? $urandom_range(hi - span, 0) : 0;
          sparse = $urandom_range(1);
        end
        pick = $urandom_range(99);
        x = lo + $urandom_range(span + 2);
        if (x > 1023) x = 1023;
        if (pick < 1) begin
          send_item(CMD_CLEAR, 10'($urandom));
        end else if (pick < 3) begin
          send_item(CMD_UNUSED, 10'($urandom));
        end else if (pick < 8) begin
          send_item(($urandom_range(1) != 0) ? CMD_QUERY : CMD_INSERT, 10'($urandom));
        end else if (pick < 35) begin
          send_item(CMD_QUERY, 10'(x));
        end else begin
          send_item(CMD_INSERT, 10'(sparse ? (x & ~1) : x));
        end
        if ($urandom_range(149) == 0) drain_results();
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = CMD_INSERT;
    pixel_x = '0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_width_extremes();
    test_full_list();
    test_random_runs();
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/srsp_pkg.sv
rtl/sorted_run_set_point_insert_core.sv
tb/sorted_run_set_point_insert_core_tb.sv
